// ===== rtl/pdtc_pkg.sv =====
// Shared constants, register codes and types of the PID drive and turn controller.
package pdtc_pkg;

  localparam int SENSOR_WIDTH_DEF   = 16;
  localparam int INTEGRAL_WIDTH_DEF = 32;

  localparam int TARGET_W   = 15;
  localparam int GAIN_W     = 16;
  localparam int LIMIT_W    = 7;
  localparam int DIR_W      = 2;
  localparam int TICK_W     = 16;
  localparam int POWER_W    = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Q8.8 gains: the weighted sum carries eight fraction bits.
  localparam int FRAC_BITS = 8;

  // In turn mode the integral term only counts while the error is below this.
  localparam int I_GATE_LIMIT = 5;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd90;
  localparam logic [DIR_W-1:0]   DIR_FORWARD = 2'b01;
  localparam logic [DIR_W-1:0]   DIR_NONE    = 2'b00;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TARGET    = 3'd0,
    REG_GAIN_P    = 3'd1,
    REG_GAIN_I    = 3'd2,
    REG_GAIN_D    = 3'd3,
    REG_LIMIT     = 3'd4,
    REG_DIRECTION = 3'd5,
    REG_TURN_MODE = 3'd6,
    REG_TIMEOUT   = 3'd7
  } cfg_reg_t;

  // Per-tick flags from the error tracker.
  typedef struct packed {
    logic active;   // tick count below timeout, outputs are computed
    logic i_gate;   // integral term is used on this tick
  } trk_flags_t;

endpackage

// ===== rtl/pdtc_err_trk.sv =====
// Error tracker: measured value, error, derivative, saturating integral and tick count.
module pdtc_err_trk
  import pdtc_pkg::*;
#(
  parameter int SENSOR_WIDTH   = SENSOR_WIDTH_DEF,
  parameter int INTEGRAL_WIDTH = INTEGRAL_WIDTH_DEF,
  localparam int EW = ((SENSOR_WIDTH > TARGET_W) ? SENSOR_WIDTH : TARGET_W) + 1,
  localparam int DW = EW + 1
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             step,
  input  logic                             start,
  input  logic signed [SENSOR_WIDTH-1:0]   sensor_a,
  input  logic signed [SENSOR_WIDTH-1:0]   sensor_b,
  input  logic        [TARGET_W-1:0]       target,
  input  logic                             turn_mode,
  input  logic        [TICK_W-1:0]         timeout_ticks,
  output trk_flags_t                       flags,
  output logic signed [EW-1:0]             err,
  output logic signed [DW-1:0]             diff,
  output logic signed [INTEGRAL_WIDTH-1:0] sum
);

  localparam int SUMW = ((INTEGRAL_WIDTH > EW) ? INTEGRAL_WIDTH : EW) + 1;
  localparam logic signed [SUMW-1:0] SAT_HI = (SUMW'(1) <<< (INTEGRAL_WIDTH - 1)) - SUMW'(1);
  localparam logic signed [SUMW-1:0] SAT_LO = -SAT_HI - SUMW'(1);

  logic signed [EW-1:0]             prev_err_r, prev_err_nxt, prev_eff;
  logic signed [INTEGRAL_WIDTH-1:0] integ_r, integ_nxt, integ_eff;
  logic        [TICK_W-1:0]         tick_r, tick_nxt, tick_eff;

  logic [SENSOR_WIDTH-1:0] abs_a, abs_b, meas;
  logic [SENSOR_WIDTH:0]   meas_sum;
  logic signed [SUMW-1:0]  sum_full;

  always_comb begin
    abs_a    = sensor_a[SENSOR_WIDTH-1] ? $unsigned(-sensor_a) : $unsigned(sensor_a);
    abs_b    = sensor_b[SENSOR_WIDTH-1] ? $unsigned(-sensor_b) : $unsigned(sensor_b);
    meas_sum = {1'b0, abs_a} + {1'b0, abs_b};
    meas     = turn_mode ? abs_a : meas_sum[SENSOR_WIDTH:1];
    err      = $signed(EW'(target)) - $signed(EW'(meas));

    // A start request wipes the history before this tick is used.
    prev_eff  = start ? '0 : prev_err_r;
    integ_eff = start ? '0 : integ_r;
    tick_eff  = start ? '0 : tick_r;

    diff     = DW'(err) - DW'(prev_eff);
    sum_full = SUMW'(integ_eff) + SUMW'(err);
    if (sum_full > SAT_HI) begin
      sum = INTEGRAL_WIDTH'(SAT_HI);
    end else if (sum_full < SAT_LO) begin
      sum = INTEGRAL_WIDTH'(SAT_LO);
    end else begin
      sum = INTEGRAL_WIDTH'(sum_full);
    end

    flags.active = (tick_eff < timeout_ticks);
    flags.i_gate = !turn_mode || (err < $signed(EW'(I_GATE_LIMIT)));

    if (flags.active) begin
      prev_err_nxt = err;
      integ_nxt    = sum;
      tick_nxt     = tick_eff + TICK_W'(1);
    end else begin
      prev_err_nxt = prev_eff;
      integ_nxt    = integ_eff;
      tick_nxt     = tick_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_err_r <= '0;
      integ_r    <= '0;
      tick_r     <= '0;
    end else if (step) begin
      prev_err_r <= prev_err_nxt;
      integ_r    <= integ_nxt;
      tick_r     <= tick_nxt;
    end
  end

endmodule

// ===== rtl/pid_drive_and_turn_controller_unit.sv =====
// Top level of the PID drive and turn controller: config registers and the tick pipeline.
// An accepted request passes the input register, error stage, product stage and output
// register before its result shows on out_tvalid.
// Throughput: one request per cycle; in_tready drops only when the output register
// is full and not taken and every stage behind it holds a request.
// Reset (rst_n low, synchronous): pipeline emptied, error history, integral, tick count
// and held powers cleared to zero, config registers back to their reset values.
module pid_drive_and_turn_controller_unit
  import pdtc_pkg::*;
#(
  parameter int SENSOR_WIDTH   = SENSOR_WIDTH_DEF,
  parameter int INTEGRAL_WIDTH = INTEGRAL_WIDTH_DEF,
  localparam int IN_TDATA_W = ((2 * SENSOR_WIDTH + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Input request channel.
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_TDATA_W-1:0] in_tdata,   // sensor_a, sensor_b, zero padding
  input  logic                  in_tuser,   // start_req
  // Result channel.
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [15:0]           out_tdata,  // left_power [7:0], right_power [15:8]
  output logic                  out_tuser,  // active
  // Configuration write channel.
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int EW  = ((SENSOR_WIDTH > TARGET_W) ? SENSOR_WIDTH : TARGET_W) + 1;
  localparam int DW  = EW + 1;
  localparam int PPW = GAIN_W + EW;
  localparam int PIW = GAIN_W + INTEGRAL_WIDTH;
  localparam int PDW = GAIN_W + DW;
  localparam int MAXW = (PPW > PIW) ? ((PPW > PDW) ? PPW : PDW) : ((PIW > PDW) ? PIW : PDW);
  localparam int AW  = MAXW + 2;
  localparam logic signed [AW-1:0] ROUND_ADD = (AW'(1) <<< FRAC_BITS) - AW'(1);

  // ---------------------------------------------------------------------------
  // Configuration registers. Writes are taken every cycle; the user must issue them only
  // while the pipeline is idle, unchecked by the block, so stages read them directly.
  // ---------------------------------------------------------------------------
  logic        [TARGET_W-1:0] target_r;
  logic signed [GAIN_W-1:0]   gain_p_r, gain_i_r, gain_d_r;
  logic        [LIMIT_W-1:0]  limit_r;
  logic        [DIR_W-1:0]    dir_r;
  logic                       turn_r;
  logic        [TICK_W-1:0]   timeout_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r  <= '0;
      gain_p_r  <= '0;
      gain_i_r  <= '0;
      gain_d_r  <= '0;
      limit_r   <= LIMIT_RESET;
      dir_r     <= DIR_FORWARD;
      turn_r    <= 1'b0;
      timeout_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_TARGET:    target_r  <= cfg_data[TARGET_W-1:0];
        REG_GAIN_P:    gain_p_r  <= $signed(cfg_data[GAIN_W-1:0]);
        REG_GAIN_I:    gain_i_r  <= $signed(cfg_data[GAIN_W-1:0]);
        REG_GAIN_D:    gain_d_r  <= $signed(cfg_data[GAIN_W-1:0]);
        REG_LIMIT:     limit_r   <= cfg_data[LIMIT_W-1:0];
        REG_DIRECTION: dir_r     <= cfg_data[DIR_W-1:0];
        REG_TURN_MODE: turn_r    <= cfg_data[0];
        REG_TIMEOUT:   timeout_r <= cfg_data[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline flow control. Each stage loads when it is empty or when the stage
  // ahead of it moves, so bubbles close up and a waiting result does not stop
  // new requests from entering behind it.
  // ---------------------------------------------------------------------------
  logic v0_r, v1_r, v2_r, vo_r;
  logic en0, en1, en2, eno;

  assign eno = !vo_r || out_tready;
  assign en2 = !v2_r || eno;
  assign en1 = !v1_r || en2;
  assign en0 = !v0_r || en1;
  assign in_tready = en0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      if (en0) v0_r <= in_tvalid;
      if (en1) v1_r <= v0_r;
      if (en2) v2_r <= v1_r;
      if (eno) vo_r <= v2_r;
    end
  end

  // Stage 0: input register.
  logic                           start0_r;
  logic signed [SENSOR_WIDTH-1:0] a0_r, b0_r;

  always_ff @(posedge clk) begin
    if (en0) begin
      start0_r <= in_tuser;
      a0_r     <= $signed(in_tdata[SENSOR_WIDTH-1:0]);
      b0_r     <= $signed(in_tdata[2*SENSOR_WIDTH-1:SENSOR_WIDTH]);
    end
  end

  // Stage 1: error, derivative and integral. The tracker's history advances
  // exactly when a request leaves the input register, which keeps the
  // tick-to-tick dependence inside this stage.
  trk_flags_t                       trk_flags, flags1_r;
  logic signed [EW-1:0]             trk_err, err1_r;
  logic signed [DW-1:0]             trk_diff, diff1_r;
  logic signed [INTEGRAL_WIDTH-1:0] trk_sum, sum1_r;

  pdtc_err_trk #(
    .SENSOR_WIDTH   (SENSOR_WIDTH),
    .INTEGRAL_WIDTH (INTEGRAL_WIDTH)
  ) u_err_trk (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (en1 && v0_r),
    .start         (start0_r),
    .sensor_a      (a0_r),
    .sensor_b      (b0_r),
    .target        (target_r),
    .turn_mode     (turn_r),
    .timeout_ticks (timeout_r),
    .flags         (trk_flags),
    .err           (trk_err),
    .diff          (trk_diff),
    .sum           (trk_sum)
  );

  always_ff @(posedge clk) begin
    if (en1) begin
      flags1_r <= trk_flags;
      err1_r   <= trk_err;
      diff1_r  <= trk_diff;
      sum1_r   <= trk_sum;
    end
  end

  // Stage 2: the three gain products, each registered. The integral product
  // is forced to zero when the turn-mode gate is closed.
  logic signed [PPW-1:0] pp2_r, pp2_nxt;
  logic signed [PIW-1:0] pi2_r, pi2_nxt;
  logic signed [PDW-1:0] pd2_r, pd2_nxt;
  logic                  act2_r;

  always_comb begin
    pp2_nxt = PPW'(gain_p_r) * PPW'(err1_r);
    pi2_nxt = flags1_r.i_gate ? (PIW'(gain_i_r) * PIW'(sum1_r)) : '0;
    pd2_nxt = PDW'(gain_d_r) * PDW'(diff1_r);
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      pp2_r  <= pp2_nxt;
      pi2_r  <= pi2_nxt;
      pd2_r  <= pd2_nxt;
      act2_r <= flags1_r.active;
    end
  end

  // Output stage: sum, drop the Q8.8 fraction toward zero, clamp, then apply
  // the direction and the turn-mode mirror.
  logic signed [AW-1:0]      acc, acc_q, lim_pos, clamped;
  logic signed [POWER_W-1:0] power, left_nxt, right_nxt;
  logic signed [POWER_W-1:0] left_r, right_r;
  logic                      active_r;

  always_comb begin
    acc     = AW'(pp2_r) + AW'(pi2_r) + AW'(pd2_r);
    acc_q   = acc[AW-1] ? ((acc + ROUND_ADD) >>> FRAC_BITS) : (acc >>> FRAC_BITS);
    lim_pos = $signed(AW'(limit_r));
    if (acc_q > lim_pos) begin
      clamped = lim_pos;
    end else if (acc_q < -lim_pos) begin
      clamped = -lim_pos;
    end else begin
      clamped = acc_q;
    end
    power = POWER_W'(clamped);

    // Any negative direction code reverses; zero silences both sides.
    if (dir_r[DIR_W-1]) begin
      left_nxt = -power;
    end else if (dir_r == DIR_NONE) begin
      left_nxt = '0;
    end else begin
      left_nxt = power;
    end
    right_nxt = turn_r ? -left_nxt : left_nxt;
  end

  // The power registers double as the held outputs: a timed-out tick leaves
  // them as they are, so it repeats the last computed command.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r   <= '0;
      right_r  <= '0;
      active_r <= 1'b0;
    end else if (eno && v2_r) begin
      active_r <= act2_r;
      if (act2_r) begin
        left_r  <= left_nxt;
        right_r <= right_nxt;
      end
    end
  end

  assign out_tvalid = vo_r;
  assign out_tdata  = {right_r, left_r};
  assign out_tuser  = active_r;

endmodule

// ===== rtl/pdtc_checker.sv =====
// Port-level checker for the PID drive and turn controller, bound to the top level.
module pdtc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic        out_tuser
);

  // Nothing comes out in the cycle after a reset.
  a_quiet_after_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result shown right after reset");

  // A result that is not taken stays put.
  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // Both sides always carry the same magnitude: equal, or mirrored in turn mode.
  a_sides_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[7:0] == out_tdata[15:8]) ||
                   (8'(out_tdata[7:0] + out_tdata[15:8]) == 8'h00))
    else $error("left and right powers differ in magnitude");

  // The clamp keeps powers within plus or minus 127.
  a_power_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[7:0] != 8'h80) && (out_tdata[15:8] != 8'h80))
    else $error("power outside the clamp range");

endmodule

bind pid_drive_and_turn_controller_unit pdtc_checker u_pdtc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the PID drive and turn controller: directed and random ticks.
module tb_top;
  import pdtc_pkg::*;

  // Cycles without any accepted request, result or register write before the run is declared hung.
  localparam int IDLE_LIMIT = 2000;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS = 30;
  localparam int LONG_MOVE_TICKS = 40;
  localparam longint SUM_MAX = 64'sd2147483647;
  localparam longint SUM_MIN = -64'sd2147483648;

  // One result: the two motor commands and the active flag.
  typedef struct packed {
    logic [7:0] left;
    logic [7:0] right;
    logic       active;
  } power_t;

  // Image of the eight configuration registers.
  typedef struct packed {
    logic [14:0] target;
    logic [15:0] kp;
    logic [15:0] ki;
    logic [15:0] kd;
    logic [6:0]  limit;
    logic [1:0]  dir;
    logic        turn;
    logic [15:0] timeout;
  } ctrl_cfg_t;

  logic                  clk;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [31:0]           in_tdata   = '0;  // sensor_a [15:0], sensor_b [31:16]
  logic                  in_tuser   = 1'b0; // start_req
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [15:0]           out_tdata;        // left_power [7:0], right_power [15:8]
  logic                  out_tuser;        // active
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;

  // Results still owed by the block, oldest first.
  power_t expected_powers[$];

  // Controller image kept by the testbench: registers and move state.
  ctrl_cfg_t   m_cfg;
  longint      prev_err;
  longint      err_sum;
  int unsigned ticks;
  logic [7:0]  held_l;
  logic [7:0]  held_r;

  int sent_cnt     = 0;
  int checked_cnt  = 0;
  int mismatch_cnt = 0;
  int cfg_cnt      = 0;
  int idle_cycles  = 0;
  // When set, both the sender and the receiver pause in random bursts.
  bit idle_en      = 1'b1;

  pid_drive_and_turn_controller_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Works out the result of one control tick and advances the move state.
  function automatic power_t predict_powers(input logic start, input logic signed [15:0] sa,
                                            input logic signed [15:0] sb);
    longint a, b, meas, err, diff, iterm, acc, pw, lim, dirv, lft, rgt;
    power_t r;
    if (start) begin
      prev_err = 0;
      err_sum  = 0;
      ticks    = 0;
    end
    // Timed out: nothing is computed, the last powers are repeated.
    if (ticks >= m_cfg.timeout) begin
      r.left   = held_l;
      r.right  = held_r;
      r.active = 1'b0;
      return r;
    end
    a = longint'(sa);
    b = longint'(sb);
    if (a < 0) a = -a;
    if (b < 0) b = -b;
    meas = m_cfg.turn ? a : (a + b) / 2;
    err  = longint'(m_cfg.target) - meas;
    diff = err - prev_err;
    prev_err = err;
    err_sum = err_sum + err;
    if (err_sum > SUM_MAX) err_sum = SUM_MAX;
    if (err_sum < SUM_MIN) err_sum = SUM_MIN;
    iterm = longint'($signed(m_cfg.ki)) * err_sum;
    // In turn mode the integral only acts close to the setpoint.
    if (m_cfg.turn && !(err < I_GATE_LIMIT)) iterm = 0;
    acc = longint'($signed(m_cfg.kp)) * err + iterm + longint'($signed(m_cfg.kd)) * diff;
    pw  = acc / (longint'(1) << FRAC_BITS);
    lim = longint'(m_cfg.limit);
    if (pw > lim) pw = lim;
    if (pw < -lim) pw = -lim;
    dirv = longint'($signed(m_cfg.dir));
    if (dirv < 0) dirv = -1;
    lft = dirv * pw;
    rgt = m_cfg.turn ? -lft : lft;
    held_l = lft[7:0];
    held_r = rgt[7:0];
    ticks  = (ticks + 1) & 32'hFFFF;
    r.left   = held_l;
    r.right  = held_r;
    r.active = 1'b1;
    return r;
  endfunction

  function automatic ctrl_cfg_t cfg_of(input logic [14:0] target, input logic [15:0] kp,
                                       input logic [15:0] ki, input logic [15:0] kd,
                                       input logic [6:0] limit, input logic [1:0] dir,
                                       input logic turn, input logic [15:0] timeout);
    ctrl_cfg_t c;
    c.target  = target;
    c.kp      = kp;
    c.ki      = ki;
    c.kd      = kd;
    c.limit   = limit;
    c.dir     = dir;
    c.turn    = turn;
    c.timeout = timeout;
    return c;
  endfunction

  // Gains are mostly moderate so that outputs do not always sit on the clamp.
  function automatic logic [15:0] random_gain();
    int g;
    if ($urandom_range(0, 5) == 0) return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
    g = int'($urandom_range(0, 2048)) - 1024;
    return g[15:0];
  endfunction

  function automatic ctrl_cfg_t random_cfg();
    ctrl_cfg_t c;
    case ($urandom_range(0, 4))
      0:       c.target = 15'd0;
      1:       c.target = 15'h7FFF;
      default: c.target = 15'($urandom_range(0, 32767));
    endcase
    c.kp = random_gain();
    c.ki = random_gain();
    c.kd = random_gain();
    case ($urandom_range(0, 4))
      0:       c.limit = 7'd0;
      1:       c.limit = 7'd127;
      default: c.limit = 7'($urandom_range(0, 127));
    endcase
    c.dir  = 2'($urandom_range(0, 3));
    c.turn = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 9))
      0:       c.timeout = 16'd0;
      1:       c.timeout = 16'hFFFF;
      default: c.timeout = 16'($urandom_range(1, 40));
    endcase
    return c;
  endfunction

  // A reading whose magnitude lies close to the setpoint, with a random sign.
  function automatic logic [15:0] near_reading(input int tgt);
    int v;
    v = tgt + int'($urandom_range(0, 127)) - 64;
    if (v < 0) v = 0;
    if (v > 32767) v = 32767;
    if ($urandom_range(0, 1)) v = -v;
    return v[15:0];
  endfunction

  function automatic void note_mismatch(input string what, input int want, input int got);
    mismatch_cnt++;
    if (mismatch_cnt <= 10)
      $display("Mismatch on %s of result %0d: expected %0d, got %0d",
               what, checked_cnt, want, got);
  endfunction

  // Sends one tick request, with an occasional gap in front of it.
  task automatic send_tick(input logic start, input logic [15:0] sa, input logic [15:0] sb);
    if (idle_en && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= start;
    in_tdata  <= {sb, sa};
    do @(posedge clk); while (!in_tready);
    expected_powers.push_back(predict_powers(start, sa, sb));
    sent_cnt++;
  endtask

  // Stops the request stream and waits until the pipeline has emptied.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (expected_powers.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // Leaves cfg_valid high; the caller lowers it after the last write.
  task automatic write_reg(input cfg_reg_t idx, input logic [15:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_TARGET:    m_cfg.target  = v[14:0];
      REG_GAIN_P:    m_cfg.kp      = v;
      REG_GAIN_I:    m_cfg.ki      = v;
      REG_GAIN_D:    m_cfg.kd      = v;
      REG_LIMIT:     m_cfg.limit   = v[6:0];
      REG_DIRECTION: m_cfg.dir     = v[1:0];
      REG_TURN_MODE: m_cfg.turn    = v[0];
      REG_TIMEOUT:   m_cfg.timeout = v;
      default: ;
    endcase
  endtask

  // Registers change only with the block idle; the move state carries over.
  task automatic apply_config(input ctrl_cfg_t c);
    wait_drained();
    write_reg(REG_TARGET, {1'b0, c.target});
    write_reg(REG_GAIN_P, c.kp);
    write_reg(REG_GAIN_I, c.ki);
    write_reg(REG_GAIN_D, c.kd);
    write_reg(REG_LIMIT, {9'd0, c.limit});
    write_reg(REG_DIRECTION, {14'd0, c.dir});
    write_reg(REG_TURN_MODE, {15'd0, c.turn});
    write_reg(REG_TIMEOUT, c.timeout);
    cfg_valid <= 1'b0;
    @(posedge clk);
    cfg_cnt++;
  endtask

  // After reset the timeout is zero, so every tick repeats the zero powers.
  task automatic test_reset_hold();
    send_tick(1'b0, 16'h7FFF, 16'h8000);
    send_tick(1'b1, 16'h8000, 16'h0001);
    send_tick(1'b0, 16'h0000, 16'hFFFF);
  endtask

  // Drive mode with sensor and gain extremes, every direction code and a zero clamp.
  task automatic test_drive_extremes();
    apply_config(cfg_of(15'h7FFF, 16'h0100, 16'h0000, 16'h0000, 7'd127, DIR_FORWARD, 1'b0,
                        16'd100));
    send_tick(1'b1, 16'h8000, 16'h7FFF);
    send_tick(1'b0, 16'h0000, 16'h0000);
    send_tick(1'b0, 16'h7FFF, 16'h8000);
    apply_config(cfg_of(15'd0, 16'h8000, 16'h7FFF, 16'h7FFF, 7'd127, 2'b11, 1'b0, 16'd100));
    send_tick(1'b1, 16'h8000, 16'h8000);
    send_tick(1'b0, 16'd100, -16'sd50);
    send_tick(1'b0, 16'h7FFF, 16'h7FFF);
    // The code for minus two must act like a plain reversal.
    apply_config(cfg_of(15'd300, 16'h0100, 16'h0010, 16'hFF80, 7'd40, 2'b10, 1'b0, 16'd50));
    send_tick(1'b1, 16'd250, -16'sd260);
    send_tick(1'b0, 16'd310, 16'd280);
    apply_config(cfg_of(15'd300, 16'h0100, 16'h0010, 16'hFF80, 7'd40, DIR_NONE, 1'b0,
                        16'd50));
    send_tick(1'b0, 16'd5, 16'd5);
    apply_config(cfg_of(15'd300, 16'h0100, 16'h0010, 16'hFF80, 7'd0, DIR_FORWARD, 1'b0,
                        16'd50));
    send_tick(1'b0, 16'd290, 16'd290);
  endtask

  // Turn mode: the integral is counted only while the error stays below the gate.
  task automatic test_turn_gate();
    apply_config(cfg_of(15'd10, 16'h0000, 16'h0100, 16'h0000, 7'd127, DIR_FORWARD, 1'b1,
                        16'd100));
    send_tick(1'b1, 16'd3, 16'h1234);
    send_tick(1'b0, -16'sd6, 16'h0000);
    send_tick(1'b0, 16'd5, 16'hFFFF);
    send_tick(1'b0, 16'd20, 16'h0000);
    apply_config(cfg_of(15'd10, 16'h0000, 16'h0100, 16'h0000, 7'd127, 2'b11, 1'b1, 16'd100));
    send_tick(1'b0, 16'h8000, 16'h5555);
  endtask

  // Timeout reached: powers are held, and a start request opens a new move.
  task automatic test_timeout_restart();
    apply_config(cfg_of(15'd1000, 16'h0200, 16'h0040, 16'h0080, 7'd90, DIR_FORWARD, 1'b0,
                        16'd2));
    send_tick(1'b1, 16'd900, 16'd950);
    send_tick(1'b0, -16'sd980, 16'd990);
    send_tick(1'b0, 16'd0, 16'd0);
    send_tick(1'b1, 16'd0, 16'd0);
  endtask

  // Long moves far from the setpoint grow the integral well past 32 bits of product.
  task automatic test_long_move();
    apply_config(cfg_of(15'h7FFF, 16'h8000, 16'h7FFF, 16'h0100, 7'd127, DIR_FORWARD, 1'b0,
                        16'hFFFF));
    send_tick(1'b1, 16'd0, 16'd0);
    repeat (LONG_MOVE_TICKS)
      send_tick(1'b0, 16'($urandom_range(0, 255)), 16'(-$urandom_range(0, 255)));
    apply_config(cfg_of(15'd0, 16'h7FFF, 16'h8000, 16'hFF00, 7'd127, 2'b11, 1'b0, 16'hFFFF));
    send_tick(1'b1, 16'h8000, 16'h8000);
    repeat (LONG_MOVE_TICKS)
      send_tick(1'b0, 16'h8000 + 16'($urandom_range(0, 255)), 16'h8000);
  endtask

  // Random configurations, each driven mostly with well-formed moves near the setpoint.
  task automatic test_random_moves();
    int n;
    int len;
    int kind;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      // The closing phases run at full rate on both sides.
      if (p >= RANDOM_PHASES - 2) idle_en = 1'b0;
      apply_config(random_cfg());
      n = 0;
      while (n < PHASE_ITEMS) begin
        send_tick(1'b1, near_reading(int'(m_cfg.target)), near_reading(int'(m_cfg.target)));
        len = $urandom_range(1, 20);
        n += len + 1;
        repeat (len) begin
          kind = $urandom_range(0, 9);
          if (kind == 0)
            send_tick(1'b0, 16'($urandom), 16'($urandom));
          else if (kind == 1)
            send_tick(1'b1, 16'($urandom), near_reading(int'(m_cfg.target)));
          else
            send_tick(1'b0, near_reading(int'(m_cfg.target)),
                      near_reading(int'(m_cfg.target)));
        end
      end
    end
  endtask

  initial begin
    m_cfg    = cfg_of(15'd0, 16'h0000, 16'h0000, 16'h0000, LIMIT_RESET, DIR_FORWARD, 1'b0,
                      16'd0);
    prev_err = 0;
    err_sum  = 0;
    ticks    = 0;
    held_l   = '0;
    held_r   = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_hold();
    test_drive_extremes();
    test_turn_gate();
    test_timeout_restart();
    test_long_move();
    test_random_moves();

    wait_drained();
    repeat (10) @(posedge clk);
    $display("Run covered %0d tick requests and %0d checked results over %0d register sets,",
             sent_cnt, checked_cnt, cfg_cnt);
    $display("both modes, all direction codes, clamp extremes, timeouts and restarts.");
    if (mismatch_cnt == 0 && expected_powers.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Receiver: random bursts of backpressure while idling is enabled.
  initial begin
    forever begin
      @(posedge clk);
      if (idle_en && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  // Every accepted result is compared with the oldest prediction.
  always @(posedge clk) begin : result_check
    power_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_powers.size() == 0) begin
        note_mismatch("unexpected result", 0, int'(out_tdata));
      end else begin
        want = expected_powers.pop_front();
        if (out_tdata[7:0] !== want.left)
          note_mismatch("left_power", int'($signed(want.left)),
                        int'($signed(out_tdata[7:0])));
        if (out_tdata[15:8] !== want.right)
          note_mismatch("right_power", int'($signed(want.right)),
                        int'($signed(out_tdata[15:8])));
        if (out_tuser !== want.active)
          note_mismatch("active", int'(want.active), int'(out_tuser));
      end
      checked_cnt++;
    end
  end

  // Watchdog: a stretch with no handshake at all means the block has hung.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout: no handshake for %0d cycles", IDLE_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
